// ----- src/dtq_pkg.sv -----
package dtq_pkg;

    localparam int TaskW  = 8;
    localparam int DelayW = 16;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [1:0] ADD_OK   = 2'd0;
    localparam logic [1:0] ADD_DUP  = 2'd1;
    localparam logic [1:0] ADD_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TaskW-1:0]  task_id;
        logic [DelayW-1:0] delay;
    } t_in_item;

    typedef struct packed {
        logic [TaskW-1:0] ready_task;
        logic             ready_found;
        logic [1:0]       add_result;
    } t_out_item;

    typedef struct packed {
        logic              used;
        logic [TaskW-1:0]  task_id;
        logic [DelayW-1:0] delay;
    } t_slot;

    typedef struct packed {
        logic       cap;
        logic       commit;
        logic [1:0] op;
        logic       add_ok;
    } t_cell_ctrl;

endpackage

// ----- src/dtq_cell.sv -----
module dtq_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dtq_pkg::t_cell_ctrl       i_ctrl,
    input  logic [dtq_pkg::TaskW-1:0] i_cap_id,
    input  dtq_pkg::t_slot            i_add,
    input  logic                      i_prev_used,
    input  logic                      i_take,
    input  dtq_pkg::t_slot            i_next,
    output dtq_pkg::t_slot            o_slot,
    output logic                      o_match,
    output logic                      o_ready
);

    logic                       r_used;
    logic                       n_used;
    logic [dtq_pkg::TaskW-1:0]  r_task;
    logic [dtq_pkg::TaskW-1:0]  n_task;
    logic [dtq_pkg::DelayW-1:0] r_delay;
    logic [dtq_pkg::DelayW-1:0] n_delay;
    logic                       r_match;
    logic                       r_ready;

    always_comb begin
        n_used  = r_used;
        n_task  = r_task;
        n_delay = r_delay;
        if (i_ctrl.commit) begin
            case (i_ctrl.op)
                dtq_pkg::OP_ADD: begin
                    if (i_ctrl.add_ok && !r_used && i_prev_used) begin
                        n_used  = 1'b1;
                        n_task  = i_add.task_id;
                        n_delay = i_add.delay;
                    end
                end
                dtq_pkg::OP_TICK: begin
                    if (r_used && (r_delay != '0)) begin
                        n_delay = r_delay - dtq_pkg::DelayW'(1);
                    end
                end
                dtq_pkg::OP_DISPATCH: begin
                    if (i_take) begin
                        n_used  = i_next.used;
                        n_task  = i_next.task_id;
                        n_delay = i_next.delay;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_delay <= '0;
        end else begin
            r_used  <= n_used;
            r_delay <= n_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
        if (i_ctrl.cap) begin
            r_match <= r_used && (r_task == i_cap_id);
            r_ready <= r_used && (r_delay == '0);
        end
    end

    assign o_slot.used    = r_used;
    assign o_slot.task_id = r_task;
    assign o_slot.delay   = r_delay;
    assign o_match        = r_match;
    assign o_ready        = r_ready;

endmodule

// ----- src/delayed_task_queue_core.sv -----
// Delayed task queue: a row of QUEUE_DEPTH slots, each holding a task id and
// its countdown delay, kept packed from slot 0 upward.
// Input channel (i_in_valid / o_in_stall / i_in_item): one operation per
// transfer. Opcode add places an id not yet queued in the first free slot, tick
// counts down every nonzero delay, dispatch removes the first queued task whose
// delay is zero and moves later slots forward by one.
// Output channel (o_out_valid / i_out_stall / o_out_item): exactly one result
// per operation, held in an output register.
// The transfer edge captures per-slot id match and ready flags, which are then
// resolved across the row, and once the output register is free or being read,
// every slot updates and the result loads. A new operation is not taken until
// the last one has updated the slots; it may be taken while a result waits in
// the output register, and while i_out_stall holds that result, the following
// operation waits before it updates the slots.
// Reset (i_rst_n low, synchronous) empties the queue and drops any result.
module delayed_task_queue_core #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtq_pkg::t_out_item o_out_item
);

    logic                r_busy;
    dtq_pkg::t_in_item   r_item;
    logic                r_out_valid;
    dtq_pkg::t_out_item  r_out;
    dtq_pkg::t_out_item  n_out;

    logic                   w_accept;
    logic                   w_commit;
    dtq_pkg::t_cell_ctrl    w_ctrl;
    dtq_pkg::t_slot         w_add;
    dtq_pkg::t_slot         w_slot [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_used;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_ready;
    logic [QUEUE_DEPTH-1:0] w_first;
    logic [QUEUE_DEPTH-1:0] w_take;
    logic                   w_dup;
    logic                   w_full;
    logic                   w_found;
    logic [dtq_pkg::TaskW-1:0] w_got;

    assign w_accept = i_in_valid && !r_busy;
    assign w_commit = r_busy && (!r_out_valid || !i_out_stall);

    assign w_dup   = |w_match;
    assign w_full  = &w_used;
    assign w_found = |w_ready;
    assign w_first = w_ready & (~w_ready + QUEUE_DEPTH'(1));
    assign w_take  = ~(w_first - QUEUE_DEPTH'(1));

    assign w_ctrl.cap    = w_accept;
    assign w_ctrl.commit = w_commit;
    assign w_ctrl.op     = r_item.opcode;
    assign w_ctrl.add_ok = !w_dup && !w_full;

    assign w_add.used    = 1'b1;
    assign w_add.task_id = r_item.task_id;
    assign w_add.delay   = r_item.delay;

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic           w_prev;
        dtq_pkg::t_slot w_nb;

        if (k == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_body
            assign w_prev = w_slot[k-1].used;
        end

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign w_nb = '0;
        end else begin : g_mid
            assign w_nb = w_slot[k+1];
        end

        dtq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_cap_id    (i_in_item.task_id),
            .i_add       (w_add),
            .i_prev_used (w_prev),
            .i_take      (w_take[k]),
            .i_next      (w_nb),
            .o_slot      (w_slot[k]),
            .o_match     (w_match[k]),
            .o_ready     (w_ready[k])
        );

        assign w_used[k] = w_slot[k].used;
    end

    always_comb begin
        w_got = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_got = w_got | (w_slot[k].task_id & {dtq_pkg::TaskW{w_first[k]}});
        end
    end

    always_comb begin
        n_out = '0;
        case (r_item.opcode)
            dtq_pkg::OP_ADD: begin
                if (w_dup) begin
                    n_out.add_result = dtq_pkg::ADD_DUP;
                end else if (w_full) begin
                    n_out.add_result = dtq_pkg::ADD_FULL;
                end else begin
                    n_out.add_result = dtq_pkg::ADD_OK;
                end
            end
            dtq_pkg::OP_DISPATCH: begin
                n_out.ready_found = w_found;
                n_out.ready_task  = w_got;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_packed_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_used & (w_used + QUEUE_DEPTH'(1))) == '0)
        else $error("occupied slots are not a packed prefix");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> $stable(w_used))
        else $error("slot occupancy changed with no operation in flight");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_item.opcode == dtq_pkg::OP_ADD) && w_ctrl.add_ok)
        |=> ($countones(w_used) == $countones($past(w_used)) + 1))
        else $error("accepted add did not occupy exactly one slot");

    a_dispatch_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_item.opcode == dtq_pkg::OP_DISPATCH) && w_found)
        |=> ($countones(w_used) + 1 == $countones($past(w_used))))
        else $error("dispatch did not free exactly one slot");

    a_commit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result produced with no operation in flight");
`endif

endmodule

// ----- tb/sv/delayed_task_queue_core_tb.sv -----
`timescale 1ns / 100ps

module delayed_task_queue_core_tb;

    localparam int QUEUE_DEPTH  = 8;
    localparam int N_RANDOM_OPS = 1650;
    localparam int STALL_LIMIT  = 1000;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 900;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    dtq_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    dtq_pkg::t_out_item o_out_item;

    dtq_pkg::t_in_item  op_backlog[$];
    dtq_pkg::t_out_item sched_results[$];
    dtq_pkg::t_out_item want;

    logic                       slot_used[QUEUE_DEPTH];
    logic [dtq_pkg::TaskW-1:0]  slot_id[QUEUE_DEPTH];
    logic [dtq_pkg::DelayW-1:0] slot_delay[QUEUE_DEPTH];

    int n_sent       = 0;
    int n_done       = 0;
    int n_fail       = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    delayed_task_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_used[k]  = 1'b0;
            slot_id[k]    = '0;
            slot_delay[k] = '0;
        end
    end

    // Apply one operation to the shadow queue and return its result.
    function automatic dtq_pkg::t_out_item run_scheduler_op(input dtq_pkg::t_in_item it);
        dtq_pkg::t_out_item res;
        int                 hit;
        bit                 done;
        res  = '0;
        hit  = -1;
        done = 1'b0;
        case (it.opcode)
            dtq_pkg::OP_ADD: begin
                res.add_result = dtq_pkg::ADD_FULL;
                for (int k = 0; k < QUEUE_DEPTH; k++) begin
                    if (!done && !slot_used[k]) begin
                        slot_used[k]   = 1'b1;
                        slot_id[k]     = it.task_id;
                        slot_delay[k]  = it.delay;
                        res.add_result = dtq_pkg::ADD_OK;
                        done           = 1'b1;
                    end else if (!done && slot_id[k] == it.task_id) begin
                        res.add_result = dtq_pkg::ADD_DUP;
                        done           = 1'b1;
                    end
                end
            end
            dtq_pkg::OP_TICK: begin
                for (int k = 0; k < QUEUE_DEPTH && slot_used[k]; k++) begin
                    if (slot_delay[k] != 0) slot_delay[k] = slot_delay[k] - 1'b1;
                end
            end
            dtq_pkg::OP_DISPATCH: begin
                for (int k = 0; k < QUEUE_DEPTH && slot_used[k] && hit < 0; k++) begin
                    if (slot_delay[k] == 0) hit = k;
                end
                if (hit >= 0) begin
                    res.ready_task  = slot_id[hit];
                    res.ready_found = 1'b1;
                    for (int k = hit; k < QUEUE_DEPTH - 1; k++) begin
                        slot_used[k]  = slot_used[k + 1];
                        slot_id[k]    = slot_id[k + 1];
                        slot_delay[k] = slot_delay[k + 1];
                    end
                    slot_used[QUEUE_DEPTH - 1]  = 1'b0;
                    slot_id[QUEUE_DEPTH - 1]    = '0;
                    slot_delay[QUEUE_DEPTH - 1] = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_op(input logic [1:0] op,
                            input logic [dtq_pkg::TaskW-1:0] id,
                            input logic [dtq_pkg::DelayW-1:0] dly);
        dtq_pkg::t_in_item it;
        it.opcode  = op;
        it.task_id = id;
        it.delay   = dly;
        op_backlog.push_back(it);
    endtask

    function automatic logic [dtq_pkg::TaskW-1:0] pick_id();
        if ($urandom_range(0, 9) == 0) return dtq_pkg::TaskW'($urandom_range(0, 255));
        return dtq_pkg::TaskW'($urandom_range(0, 15));
    endfunction

    function automatic logic [dtq_pkg::DelayW-1:0] pick_delay();
        if ($urandom_range(0, 19) == 0) return dtq_pkg::DelayW'($urandom_range(0, 40));
        return dtq_pkg::DelayW'($urandom_range(0, 6));
    endfunction

    function automatic bit take_break(input int n);
        return (n < QUIET_FROM || n >= QUIET_TO) && ($urandom_range(0, 99) < 28);
    endfunction

    task automatic build_stimulus();
        int sel;
        int len;
        queue_op(dtq_pkg::OP_DISPATCH, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_TICK, 8'd0, 16'd0);
        queue_op(OP_UNUSED, 8'hff, 16'hffff);
        queue_op(dtq_pkg::OP_ADD, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_ADD, 8'd0, 16'd5);
        queue_op(dtq_pkg::OP_ADD, 8'd255, 16'hffff);
        queue_op(dtq_pkg::OP_ADD, 8'ha5, 16'd1);
        queue_op(dtq_pkg::OP_ADD, 8'h5a, 16'd2);
        queue_op(dtq_pkg::OP_ADD, 8'd1, 16'd0);
        queue_op(dtq_pkg::OP_ADD, 8'd2, 16'd3);
        queue_op(dtq_pkg::OP_ADD, 8'd3, 16'd0);
        queue_op(dtq_pkg::OP_ADD, 8'd4, 16'd1);
        queue_op(dtq_pkg::OP_ADD, 8'd9, 16'h8000);
        queue_op(dtq_pkg::OP_ADD, 8'ha5, 16'd0);
        queue_op(dtq_pkg::OP_DISPATCH, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_DISPATCH, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_TICK, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_TICK, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_DISPATCH, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_DISPATCH, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_DISPATCH, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_TICK, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_DISPATCH, 8'd0, 16'd0);
        queue_op(dtq_pkg::OP_DISPATCH, 8'd0, 16'd0);
        queue_op(OP_UNUSED, 8'd0, 16'd0);
        while (op_backlog.size() < N_RANDOM_OPS + 25) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                len = $urandom_range(1, 9);
                repeat (len) queue_op(dtq_pkg::OP_ADD, pick_id(), pick_delay());
            end else if (sel < 55) begin
                len = $urandom_range(1, 4);
                repeat (len) queue_op(dtq_pkg::OP_TICK, pick_id(), pick_delay());
            end else if (sel < 85) begin
                len = $urandom_range(1, 6);
                repeat (len) queue_op(dtq_pkg::OP_DISPATCH, pick_id(), pick_delay());
            end else begin
                queue_op(2'($urandom_range(0, 3)),
                         dtq_pkg::TaskW'($urandom_range(0, 255)),
                         pick_delay());
            end
        end
    endtask

    // Sender: one transfer per accepted item, valid held until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                sched_results.push_back(run_scheduler_op(i_in_item));
                n_sent <= n_sent + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (op_backlog.size() != 0 && !take_break(n_sent)) begin
                    i_in_item  <= op_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && n_done >= 400) begin
            hold_done   <= 1'b1;
            hold_left   <= 100;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= take_break(n_done);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_done <= n_done + 1;
            if (sched_results.size() == 0) begin
                $error("result transfer with no operation outstanding");
                n_fail++;
            end else begin
                want = sched_results.pop_front();
                if (o_out_item.ready_task !== want.ready_task) begin
                    $error("ready_task expected %0d actual %0d",
                           want.ready_task, o_out_item.ready_task);
                    n_fail++;
                end
                if (o_out_item.ready_found !== want.ready_found) begin
                    $error("ready_found expected %0d actual %0d",
                           want.ready_found, o_out_item.ready_found);
                    n_fail++;
                end
                if (o_out_item.add_result !== want.add_result) begin
                    $error("add_result expected %0d actual %0d",
                           want.add_result, o_out_item.add_result);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("delayed_task_queue_core: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (op_backlog.size() != 0 || i_in_valid || sched_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("delayed_task_queue_core: match");
        end else begin
            $display("delayed_task_queue_core: mismatch");
        end
        $finish;
    end

endmodule
